### src/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared constants, codes and transfer types of the cache directory.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int unsigned ENTRIES = 10;
  localparam int unsigned IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned SLOT_W  = 6;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  typedef struct packed {
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [KEY_W-1:0]   wr_key;
    logic [STAMP_W-1:0] wr_stamp;
  } mem_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]   rd_key;
    logic [STAMP_W-1:0] rd_stamp;
  } mem_rsp_t;

endpackage

### src/lcd_store.sv
// ----------------------------------------------------------------------------
// lcd_store
// Entry storage: key and stamp memory with a registered read, plus valid flags.
// ----------------------------------------------------------------------------
module lcd_store (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcd_pkg::mem_req_t             mem_req_i,
  output lcd_pkg::mem_rsp_t             mem_rsp_o,
  output logic [lcd_pkg::ENTRIES-1:0]   valid_o
);

  lcd_pkg::mem_rsp_t                 mem_q [lcd_pkg::ENTRIES];
  lcd_pkg::mem_rsp_t                 rd_data_q;
  logic [lcd_pkg::ENTRIES-1:0]       valid_q;

  always_ff @(posedge clk_i) begin
    if (mem_req_i.wr_en) begin
      mem_q[mem_req_i.wr_addr] <= '{rd_key: mem_req_i.wr_key, rd_stamp: mem_req_i.wr_stamp};
    end
    if (mem_req_i.rd_en) begin
      rd_data_q <= mem_q[mem_req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_req_i.wr_en) begin
      valid_q[mem_req_i.wr_addr] <= 1'b1;
    end
  end

  assign mem_rsp_o = rd_data_q;
  assign valid_o   = valid_q;

endmodule

### src/lcd_scan.sv
// ----------------------------------------------------------------------------
// lcd_scan
// Sequencer that walks the entries, picks the hit or the victim and writes back.
// ----------------------------------------------------------------------------
module lcd_scan (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  lcd_pkg::req_t                 req_i,
  output logic                          busy_o,
  output logic                          done_o,
  output lcd_pkg::rsp_t                 rsp_o,
  output lcd_pkg::mem_req_t             mem_req_o,
  input  lcd_pkg::mem_rsp_t             mem_rsp_i,
  input  logic [lcd_pkg::ENTRIES-1:0]   valid_i
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic                            op_q, op_d;
  logic [lcd_pkg::KEY_W-1:0]       key_q, key_d;
  logic [lcd_pkg::CNT_W-1:0]       rd_idx_q, rd_idx_d;
  logic                            chk_vld_q, chk_vld_d;
  logic [lcd_pkg::IDX_W-1:0]       chk_idx_q, chk_idx_d;
  logic [lcd_pkg::IDX_W-1:0]       best_idx_q, best_idx_d;
  logic [lcd_pkg::STAMP_W-1:0]     best_stamp_q, best_stamp_d;
  logic [lcd_pkg::STAMP_W-1:0]     cnt_q, cnt_d, cnt_next;
  logic                            done_q, done_d;
  lcd_pkg::rsp_t                   rsp_q, rsp_d;
  logic                            free_any;
  logic [lcd_pkg::IDX_W-1:0]       free_idx;
  logic                            chk_last;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = lcd_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid_i[i]) begin
        free_any = 1'b1;
        free_idx = lcd_pkg::IDX_W'(i);
      end
    end
  end

  assign cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign chk_last = (chk_idx_q == lcd_pkg::IDX_W'(lcd_pkg::ENTRIES - 1));

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    key_d        = key_q;
    rd_idx_d     = rd_idx_q;
    chk_vld_d    = chk_vld_q;
    chk_idx_d    = chk_idx_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    cnt_d        = cnt_q;
    done_d       = 1'b0;
    rsp_d        = rsp_q;
    mem_req_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d      = req_i.op;
          key_d     = req_i.key;
          rd_idx_d  = '0;
          chk_vld_d = 1'b0;
          if (req_i.op == lcd_pkg::OP_INSERT && free_any) begin
            best_idx_d = free_idx;
            state_d    = S_WRITE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        mem_req_o.rd_en   = (rd_idx_q < lcd_pkg::CNT_W'(lcd_pkg::ENTRIES));
        mem_req_o.rd_addr = rd_idx_q[lcd_pkg::IDX_W-1:0];
        chk_vld_d         = mem_req_o.rd_en;
        if (mem_req_o.rd_en) begin
          rd_idx_d  = rd_idx_q + 1'b1;
          chk_idx_d = rd_idx_q[lcd_pkg::IDX_W-1:0];
        end
        if (chk_vld_q) begin
          if (op_q == lcd_pkg::OP_LOOKUP) begin
            if (valid_i[chk_idx_q] && mem_rsp_i.rd_key == key_q) begin
              best_idx_d = chk_idx_q;
              state_d    = S_WRITE;
            end else if (chk_last) begin
              done_d  = 1'b1;
              rsp_d   = '{hit: 1'b0, slot: '0};
              state_d = S_IDLE;
            end
          end else begin
            if (chk_idx_q == '0 || mem_rsp_i.rd_stamp < best_stamp_q) begin
              best_idx_d   = chk_idx_q;
              best_stamp_d = mem_rsp_i.rd_stamp;
            end
            if (chk_last) begin
              state_d = S_WRITE;
            end
          end
        end
      end
      S_WRITE: begin
        mem_req_o.wr_en    = 1'b1;
        mem_req_o.wr_addr  = best_idx_q;
        mem_req_o.wr_key   = key_q;
        mem_req_o.wr_stamp = cnt_next;
        cnt_d              = cnt_next;
        done_d             = 1'b1;
        rsp_d.hit          = (op_q == lcd_pkg::OP_LOOKUP);
        rsp_d.slot         = lcd_pkg::SLOT_W'(best_idx_q);
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_idx_q  <= '0;
      chk_vld_q <= 1'b0;
      cnt_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_idx_q  <= rd_idx_d;
      chk_vld_q <= chk_vld_d;
      cnt_q     <= cnt_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    chk_idx_q    <= chk_idx_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    rsp_q        <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_write_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WRITE |=> done_q)
    else $error("write-back not followed by a result transfer");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == S_IDLE)
    else $error("result transfer while the sequencer is still working");

  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> !mem_req_o.rd_en)
    else $error("memory read and write in the same cycle");

  a_rd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.rd_en |-> rd_idx_q < lcd_pkg::CNT_W'(lcd_pkg::ENTRIES))
    else $error("memory read beyond the last entry");

  a_cnt_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_WRITE |=> $stable(cnt_q))
    else $error("use counter changed outside a write-back");

endmodule

### src/lru_cache_directory.sv
// ----------------------------------------------------------------------------
// lru_cache_directory
// Directory of a small fully associative cache with timestamp LRU replacement.
// ----------------------------------------------------------------------------
// A request (op, key) is transferred at a rising edge where start is high
// and busy is low. A lookup searches the valid entries for the key, lowest
// index first; on a hit the entry's stamp is refreshed from the saturating
// use counter. An insert takes the first empty entry, or else the entry with
// the smallest stamp, and writes the key with a fresh stamp.
// Each request yields exactly one result on rsp_o, marked by done_o for one
// cycle; the receiver cannot stall it and must take it in that cycle.
// The key/stamp memory has one read port with a registered read and is read
// one entry per cycle during a scan. A lookup ends at the first hit, or after
// the last entry on a miss; an insert into a full directory scans every entry
// before it writes. An insert while an entry is still empty skips the scan.
// busy stays high until the result is produced; a new request may be
// transferred in the cycle that done_o is high.
// Reset clears the valid flags and the use counter; no clearing pass is run.
// ----------------------------------------------------------------------------
module lru_cache_directory (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  lcd_pkg::req_t  req_i,
  output logic           busy,
  output logic           done_o,
  output lcd_pkg::rsp_t  rsp_o
);

  lcd_pkg::mem_req_t               mem_req;
  lcd_pkg::mem_rsp_t               mem_rsp;
  logic [lcd_pkg::ENTRIES-1:0]     valid;

  lcd_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req_i),
    .busy_o    (busy),
    .done_o    (done_o),
    .rsp_o     (rsp_o),
    .mem_req_o (mem_req),
    .mem_rsp_i (mem_rsp),
    .valid_i   (valid)
  );

  lcd_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mem_req_i (mem_req),
    .mem_rsp_o (mem_rsp),
    .valid_o   (valid)
  );

endmodule

### tb/tb_lru_cache_directory.sv
// ----------------------------------------------------------------------------
// tb_lru_cache_directory
// Self-checking testbench for the LRU cache directory.
// ----------------------------------------------------------------------------
// Lookups and inserts are sent in random bursts and checked against a
// behavioral copy of the directory that tracks valid flags, keys, stamps and
// the saturating use counter. Directed tests cover the empty directory, the
// extreme keys, filling every entry, hits on every third slot, duplicate inserts
// and eviction of the least recently used entry; a long random test follows.
// ----------------------------------------------------------------------------
module tb_lru_cache_directory;
  timeunit 1ns;
  timeprecision 1ps;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  lcd_pkg::req_t req_i;
  logic          busy;
  logic          done_o;
  lcd_pkg::rsp_t rsp_o;

  bit                        dir_valid [lcd_pkg::ENTRIES];
  bit [lcd_pkg::KEY_W-1:0]   dir_key   [lcd_pkg::ENTRIES];
  bit [lcd_pkg::STAMP_W-1:0] dir_stamp [lcd_pkg::ENTRIES];
  bit [lcd_pkg::STAMP_W-1:0] use_count;

  lcd_pkg::rsp_t pending_rsps[$];
  int            failures;
  int            burst_left;

  lru_cache_directory u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bit [lcd_pkg::STAMP_W-1:0] bump_use_count();
    if (use_count != '1) begin
      use_count = use_count + 1'b1;
    end
    return use_count;
  endfunction

  function automatic lcd_pkg::rsp_t predict_access(lcd_pkg::req_t r);
    lcd_pkg::rsp_t res;
    int            victim;
    res    = '0;
    victim = -1;
    if (r.op == lcd_pkg::OP_LOOKUP) begin
      for (int i = 0; i < lcd_pkg::ENTRIES; i++) begin
        if (dir_valid[i] && dir_key[i] == r.key) begin
          dir_stamp[i] = bump_use_count();
          res.hit      = 1'b1;
          res.slot     = lcd_pkg::SLOT_W'(i);
          return res;
        end
      end
      return res;
    end
    for (int i = 0; i < lcd_pkg::ENTRIES; i++) begin
      if (!dir_valid[i] && victim < 0) begin
        victim = i;
      end
    end
    if (victim < 0) begin
      victim = 0;
      for (int i = 1; i < lcd_pkg::ENTRIES; i++) begin
        if (dir_stamp[i] < dir_stamp[victim]) begin
          victim = i;
        end
      end
    end
    dir_valid[victim] = 1'b1;
    dir_key[victim]   = r.key;
    dir_stamp[victim] = bump_use_count();
    res.slot          = lcd_pkg::SLOT_W'(victim);
    return res;
  endfunction

  // Holds start high until the request is taken, then records its expected result.
  task automatic issue_request(input logic op, input logic [lcd_pkg::KEY_W-1:0] key);
    lcd_pkg::req_t r;
    r.op  = op;
    r.key = key;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pending_rsps.push_back(predict_access(r));
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic send(input logic op, input logic [lcd_pkg::KEY_W-1:0] key);
    issue_request(op, key);
    pace();
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    lcd_pkg::rsp_t exp_rsp;
    if (rst_ni && done_o) begin
      if (pending_rsps.size() == 0) begin
        $error("unexpected result transfer: hit=%0b slot=%0d", rsp_o.hit, rsp_o.slot);
        failures++;
      end else begin
        exp_rsp = pending_rsps.pop_front();
        if (rsp_o.hit !== exp_rsp.hit) begin
          $error("hit mismatch: expected %0b, actual %0b", exp_rsp.hit, rsp_o.hit);
          failures++;
        end
        if (rsp_o.slot !== exp_rsp.slot) begin
          $error("slot mismatch: expected %0d, actual %0d", exp_rsp.slot, rsp_o.slot);
          failures++;
        end
      end
    end
  end

  task automatic test_empty_lookup();
    send(lcd_pkg::OP_LOOKUP, '0);
    send(lcd_pkg::OP_LOOKUP, '1);
  endtask

  task automatic test_fill_and_hit();
    logic [lcd_pkg::KEY_W-1:0] fill_keys [lcd_pkg::ENTRIES];
    fill_keys[0] = '0;
    fill_keys[1] = '1;
    fill_keys[2] = 64'hAAAA_AAAA_AAAA_AAAA;
    fill_keys[3] = 64'h5555_5555_5555_5555;
    for (int i = 4; i < lcd_pkg::ENTRIES; i++) begin
      fill_keys[i] = {$urandom, $urandom};
    end
    for (int i = 0; i < lcd_pkg::ENTRIES; i++) begin
      send(lcd_pkg::OP_INSERT, fill_keys[i]);
    end
    for (int i = lcd_pkg::ENTRIES - 1; i >= 0; i -= 3) begin
      send(lcd_pkg::OP_LOOKUP, fill_keys[i]);
    end
    send(lcd_pkg::OP_LOOKUP, 64'h0123_4567_89AB_CDEF);
    wait_drained();
  endtask

  task automatic test_duplicate_and_evict();
    send(lcd_pkg::OP_INSERT, '1);
    send(lcd_pkg::OP_LOOKUP, '1);
    send(lcd_pkg::OP_INSERT, 64'h8000_0000_0000_0001);
    send(lcd_pkg::OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFE);
    send(lcd_pkg::OP_LOOKUP, 64'h8000_0000_0000_0001);
    send(lcd_pkg::OP_LOOKUP, '0);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [lcd_pkg::KEY_W-1:0] key_pool [16];
    int                        pick;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 16; i++) begin
      key_pool[i] = {$urandom, $urandom};
    end
    for (int n = 0; n < 400; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send(lcd_pkg::OP_LOOKUP, key_pool[$urandom_range(0, 15)]);
      end else if (pick < 85) begin
        send(lcd_pkg::OP_INSERT, key_pool[$urandom_range(0, 15)]);
      end else if (pick < 92) begin
        send(lcd_pkg::OP_LOOKUP, {$urandom, $urandom});
      end else begin
        key_pool[$urandom_range(2, 15)] = {$urandom, $urandom};
        send(lcd_pkg::OP_INSERT, {$urandom, $urandom});
      end
      if (n == 200) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    failures   = 0;
    burst_left = 0;
    use_count  = '0;
    for (int i = 0; i < lcd_pkg::ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_key[i]   = '0;
      dir_stamp[i] = '0;
    end
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_lookup();
    test_fill_and_hit();
    test_duplicate_and_evict();
    test_random_traffic();

    wait_drained();
    repeat (lcd_pkg::ENTRIES + 6) @(posedge clk_i);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule

### lru_cache_directory.f
src/lcd_pkg.sv
src/lcd_store.sv
src/lcd_scan.sv
src/lru_cache_directory.sv
tb/tb_lru_cache_directory.sv
